// ===== rtl/psc_pkg.sv =====
`default_nettype none

package psc_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    KIND_PUSH = 3'd0,
    KIND_ADD  = 3'd1,
    KIND_SUB  = 3'd2,
    KIND_MUL  = 3'd3,
    KIND_DIV  = 3'd4,
    KIND_NEG  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_DIVZERO   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  localparam logic [DataW-1:0] ErrValue = {DataW{1'b1}};

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/psc_ram.sv =====
`default_nettype none

module psc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/psc_div.sv =====
`default_nettype none

module psc_div
  import psc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [4:0]       step_q, step_d;
  logic             neg_q, neg_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] div_q, div_d;
  logic [DataW:0]   rem_shift;
  logic [DataW+1:0] diff;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign rem_shift = {rem_q, quo_q[DataW-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      neg_d  = req_i.dividend[DataW-1] ^ req_i.divisor[DataW-1];
      rem_d  = '0;
      quo_d  = req_i.dividend[DataW-1] ? (DataW'(0) - req_i.dividend) : req_i.dividend;
      div_d  = req_i.divisor[DataW-1] ? (DataW'(0) - req_i.divisor) : req_i.divisor;
    end else if (busy_q) begin
      if (!diff[DataW+1]) begin
        rem_d = diff[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      step_d = step_q + 5'd1;
      if (step_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (DataW'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

// ===== rtl/postfix_stack_calculator.sv =====
// Postfix calculator over a stack of 32-bit signed integers.
// Input channel: kind_i and operand_value_i with in_valid_i; the block drives
// in_stall_o and takes a transaction when valid is high and stall is low.
// Output channel: top_value_o and status_o with out_valid_o; the receiver
// drives out_stall_i. Every input transaction gives exactly one result.
// From acceptance, a push or any error found from the count alone goes straight
// to S_DONE; negate and an unused kind first read the top entry in S_RD1; add,
// subtract, multiply and a zero divisor read both operands in S_RD1 and S_RD2
// and compute in S_EXEC; divide also waits in S_DIVW on the bit-serial divider.
// One item is in work at a time: no new item is taken until the last one has
// left S_DONE. The stack lives in a single-port-read RAM with a registered
// read, so two operands take two successive reads.
// A finished result sits in an output register; while the receiver stalls,
// the block still accepts and works on the next item and holds its result
// until the register frees. Reset empties the stack and clears the output
// valid; the stack RAM itself is not cleared.
`default_nettype none

module postfix_stack_calculator
  import psc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic        [2:0]  kind_i,
  input  wire logic signed [31:0] operand_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed      [31:0] top_value_o,
  output logic             [1:0]  status_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [2:0]       kind_q, kind_d;
  logic [DataW-1:0] a_q, a_d;
  logic [DataW-1:0] b_q, b_d;
  logic [DataW-1:0] res_q, res_d;
  status_e          st_q, st_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] top_q, top_d;
  status_e          status_q, status_d;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [DataW-1:0] mem_rdata;

  logic [CW-1:0]    cnt_m1;
  logic [CW-1:0]    cnt_m2;
  logic             full;
  logic [DataW-1:0] prod;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign cnt_m1 = count_q - CW'(1);
  assign cnt_m2 = count_q - CW'(2);
  assign full   = (count_q == CW'(STACK_DEPTH));
  assign prod   = a_q * b_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    kind_d      = kind_q;
    a_d         = a_q;
    b_d         = b_q;
    res_d       = res_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && out_stall_i;
    top_d       = top_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_m2[AW-1:0];
    mem_wdata   = res_q;
    mem_raddr   = cnt_m1[AW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = a_q;
    div_req.divisor  = b_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d = kind_i;
          unique case (kind_i) inside
            KIND_PUSH: begin
              if (full) begin
                res_d = ErrValue;
                st_d  = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[AW-1:0];
                mem_wdata = operand_value_i;
                count_d   = count_q + CW'(1);
                res_d     = operand_value_i;
                st_d      = ST_OK;
              end
              state_d = S_DONE;
            end
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
              if (count_q < CW'(2)) begin
                res_d   = ErrValue;
                st_d    = ST_UNDERFLOW;
                state_d = S_DONE;
              end else begin
                state_d = S_RD1;
              end
            end
            default: begin
              // Negate and the unused kinds need only the top entry.
              if (count_q == '0) begin
                res_d   = ErrValue;
                st_d    = ST_UNDERFLOW;
                state_d = S_DONE;
              end else begin
                state_d = S_RD1;
              end
            end
          endcase
        end
      end
      S_RD1: begin
        b_d = mem_rdata;
        unique case (kind_q) inside
          KIND_NEG: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_m1[AW-1:0];
            mem_wdata = DataW'(0) - mem_rdata;
            res_d     = DataW'(0) - mem_rdata;
            st_d      = ST_OK;
            state_d   = S_DONE;
          end
          KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
            mem_raddr = cnt_m2[AW-1:0];
            state_d   = S_RD2;
          end
          default: begin
            res_d   = mem_rdata;
            st_d    = ST_OK;
            state_d = S_DONE;
          end
        endcase
      end
      S_RD2: begin
        a_d     = mem_rdata;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        st_d    = ST_OK;
        unique case (kind_q) inside
          KIND_ADD: res_d = a_q + b_q;
          KIND_SUB: res_d = a_q - b_q;
          KIND_MUL: res_d = prod;
          KIND_DIV: begin
            if (b_q == '0) begin
              res_d   = ErrValue;
              st_d    = ST_DIVZERO;
              count_d = cnt_m2;
            end else begin
              div_req.start = 1'b1;
              state_d       = S_DIVW;
            end
          end
          default: begin
            res_d = ErrValue;
            st_d  = ST_UNDERFLOW;
          end
        endcase
        if (kind_q == KIND_ADD || kind_q == KIND_SUB || kind_q == KIND_MUL) begin
          mem_we    = 1'b1;
          mem_wdata = res_d;
          count_d   = cnt_m1;
        end
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          mem_wdata = div_rsp.quotient;
          count_d   = cnt_m1;
          res_d     = div_rsp.quotient;
          st_d      = ST_OK;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          top_d       = res_q;
          status_d    = st_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    a_q      <= a_d;
    b_q      <= b_d;
    res_q    <= res_d;
    st_q     <= st_d;
    top_q    <= top_d;
    status_q <= status_d;
  end

  psc_ram #(
    .WIDTH (DataW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  psc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign top_value_o = top_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import psc_pkg::*;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned RandomItems = 1350;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 50;
  localparam int unsigned MaxPrinted = 40;

  // Kind codes that the block does not define; they report the current top.
  localparam logic [2:0] KindSpare0 = 3'd6;
  localparam logic [2:0] KindSpare1 = 3'd7;

  localparam logic [31:0] MinInt = 32'h8000_0000;
  localparam logic [31:0] MaxInt = 32'h7fff_ffff;
  localparam logic [31:0] MinusOne = 32'hffff_ffff;

  typedef enum int {
    RxFree,
    RxLight,
    RxHeavy,
    RxPeriodic
  } rx_mode_e;

  typedef struct {
    logic [31:0] top;
    status_e     status;
  } calc_result_t;

  class rpn_checker;
    logic [31:0]  stack_mem [StackDepth];
    int unsigned  depth = 0;
    calc_result_t pending_q [$];
    int unsigned  mismatch_count = 0;

    function void report(string msg);
      mismatch_count++;
      if (mismatch_count <= MaxPrinted) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endfunction

    // Applies one accepted transaction to the stack copy and queues its result.
    function void note_input(logic [2:0] kind, logic [31:0] operand);
      calc_result_t want;
      logic [31:0]  lhs;
      logic [31:0]  rhs;
      logic [31:0]  res;
      logic [31:0]  mag_l;
      logic [31:0]  mag_r;
      want.top = ErrValue;
      want.status = ST_UNDERFLOW;
      res = '0;
      case (kind)
        KIND_PUSH: begin
          if (depth >= StackDepth) begin
            want.status = ST_FULL;
          end else begin
            stack_mem[depth] = operand;
            depth++;
            want.top = operand;
            want.status = ST_OK;
          end
        end
        KIND_NEG: begin
          if (depth > 0) begin
            stack_mem[depth-1] = 32'd0 - stack_mem[depth-1];
            want.top = stack_mem[depth-1];
            want.status = ST_OK;
          end
        end
        KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
          if (depth >= 2) begin
            rhs = stack_mem[depth-1];
            lhs = stack_mem[depth-2];
            depth -= 2;
            case (kind)
              KIND_ADD: res = lhs + rhs;
              KIND_SUB: res = lhs - rhs;
              KIND_MUL: res = lhs * rhs;
              default: begin
                // Divide magnitudes, then fix the sign: truncates toward zero.
                if (rhs != '0) begin
                  mag_l = lhs[31] ? 32'd0 - lhs : lhs;
                  mag_r = rhs[31] ? 32'd0 - rhs : rhs;
                  res = mag_l / mag_r;
                  if (lhs[31] ^ rhs[31]) begin
                    res = 32'd0 - res;
                  end
                end
              end
            endcase
            if (kind == KIND_DIV && rhs == '0) begin
              want.status = ST_DIVZERO;
            end else begin
              stack_mem[depth] = res;
              depth++;
              want.top = res;
              want.status = ST_OK;
            end
          end
        end
        default: begin
          if (depth > 0) begin
            want.top = stack_mem[depth-1];
            want.status = ST_OK;
          end
        end
      endcase
      pending_q.push_back(want);
    endfunction

    function void check_result(logic [31:0] top, logic [1:0] status);
      calc_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result top=%0d status=%0d", $signed(top), status));
        return;
      end
      want = pending_q.pop_front();
      if (top !== want.top) begin
        report($sformatf("top_value %0d, expected %0d", $signed(top), $signed(want.top)));
      end
      if (status !== want.status) begin
        report($sformatf("status %0d, expected %0d", status, want.status));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_q = '0;
  logic [31:0] operand_q = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [31:0] top_value_o;
  logic [1:0]  status_o;

  rpn_checker  calc_model = new();
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned random_sent = 0;
  rx_mode_e    stall_mode = RxFree;
  int unsigned stall_span = 0;

  postfix_stack_calculator #(
    .STACK_DEPTH(StackDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_q),
    .operand_value_i(operand_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .top_value_o    (top_value_o),
    .status_o       (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("FAIL postfix_stack_calculator");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_n && in_valid && !in_stall_o) begin
      calc_model.note_input(kind_q, operand_q);
    end
    if (rst_n && out_valid_o && !out_stall) begin
      calc_model.check_result(top_value_o, status_o);
    end
  end

  // The receiver changes its stall behavior each time its random span runs out.
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= rx_mode_e'($urandom_range(0, 3));
      stall_span <= $urandom_range(20, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      RxFree:     out_stall <= 1'b0;
      RxLight:    out_stall <= ($urandom_range(0, 2) == 0);
      RxHeavy:    out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= ((stall_span % 16) < 11);
    endcase
  end

  task automatic send_item(input logic [2:0] kind, input logic [31:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    kind_q <= kind;
    operand_q <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // push_pct is the chance in percent that the transaction is a push.
  task automatic send_random(input int unsigned push_pct);
    logic [2:0]  kind;
    logic [31:0] value;
    int unsigned pick;
    case ($urandom_range(0, 7))
      0:       value = '0;
      1:       value = $urandom_range(0, 16) - 8;
      2: begin
        pick = $urandom_range(0, 3);
        value = (pick == 0) ? MinInt : (pick == 1) ? MaxInt : (pick == 2) ? MinusOne : 32'd1;
      end
      3:       value = $urandom_range(0, 2000) - 1000;
      default: value = $urandom;
    endcase
    if ($urandom_range(0, 99) < push_pct) begin
      kind = KIND_PUSH;
    end else begin
      pick = $urandom_range(0, 11);
      if (pick < 10) begin
        kind = 3'(KIND_ADD + pick / 2);
      end else begin
        kind = (pick == 10) ? KindSpare0 : KindSpare1;
      end
    end
    send_item(kind, value);
    random_sent++;
  endtask

  initial begin
    int unsigned phase_len;
    int unsigned push_pct;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Errors on an empty or nearly empty stack.
    send_item(KIND_NEG, MinusOne);
    send_item(KIND_ADD, '0);
    send_item(KindSpare1, MaxInt);
    send_item(KIND_PUSH, MinInt);
    send_item(KIND_SUB, '0);
    // The most negative value negates to itself and divides by -1 to itself.
    send_item(KIND_NEG, '0);
    send_item(KindSpare0, '0);
    send_item(KIND_PUSH, MinusOne);
    send_item(KIND_DIV, '0);
    send_item(KIND_PUSH, MaxInt);
    send_item(KIND_ADD, '0);
    // A zero divisor still consumes both operands.
    send_item(KIND_PUSH, '0);
    send_item(KIND_DIV, MaxInt);
    send_item(KIND_PUSH, 32'd7);
    send_item(KIND_PUSH, 32'hffff_fffe);
    send_item(KIND_DIV, '0);
    send_item(KIND_PUSH, MaxInt);
    send_item(KIND_MUL, '0);
    send_item(KIND_PUSH, MinInt);
    send_item(KIND_SUB, '0);
    send_item(KIND_PUSH, 32'hffff_fff9);
    send_item(KIND_PUSH, 32'd2);
    send_item(KIND_DIV, '0);
    send_item(KIND_MUL, '0);
    send_item(KIND_NEG, '0);

    // Fill past the top, then apply operations only, which drain the stack.
    repeat (70) send_random(100);
    repeat (75) send_random(0);
    while (random_sent < RandomItems) begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(0, 5))
        0:       push_pct = 0;
        1:       push_pct = 25;
        2:       push_pct = 50;
        3:       push_pct = 65;
        4:       push_pct = 80;
        default: push_pct = 100;
      endcase
      repeat (phase_len) send_random(push_pct);
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (calc_model.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (calc_model.mismatch_count == 0) begin
      $display("PASS postfix_stack_calculator");
    end else begin
      $display("FAIL postfix_stack_calculator");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/psc_pkg.sv
rtl/psc_ram.sv
rtl/psc_div.sv
rtl/postfix_stack_calculator.sv
tb/tb.sv
